@@ hdl/rbes_pkg.sv @@
package rbes_pkg;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 6;
  localparam int RAM_DEPTH = 64;
  localparam int PC_W      = 7;
  localparam int ACC_W     = 50;
  localparam int OPND_W    = 34;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int NORM_ITERATIONS_DEF = 3;

  localparam logic [1:0] CFG_IMASS  = 2'd0;
  localparam logic [1:0] CFG_DT     = 2'd1;
  localparam logic [1:0] CFG_LKEEP  = 2'd2;
  localparam logic [1:0] CFG_AKEEP  = 2'd3;

  localparam logic [30:0] IMASS_RST = 31'd65536;
  localparam logic [16:0] DT_RST    = 17'd1092;
  localparam logic [16:0] KEEP_RST  = 17'd65536;

  // state memory map
  localparam logic [ADDR_W-1:0] AP   = 6'd0;
  localparam logic [ADDR_W-1:0] AQ   = 6'd3;
  localparam logic [ADDR_W-1:0] AV   = 6'd7;
  localparam logic [ADDR_W-1:0] AW   = 6'd10;
  localparam logic [ADDR_W-1:0] AT   = 6'd13;
  localparam logic [ADDR_W-1:0] AH   = 6'd28;
  localparam logic [ADDR_W-1:0] ATMP = 6'd31;
  localparam logic [ADDR_W-1:0] AQN  = 6'd32;

  localparam logic [2:0] A_RAM  = 3'd0;
  localparam logic [2:0] A_IN   = 3'd1;
  localparam logic [2:0] A_M    = 3'd2;
  localparam logic [2:0] A_R    = 3'd3;
  localparam logic [2:0] A_SEED = 3'd4;
  localparam logic [2:0] A_Q30  = 3'd5;
  localparam logic [2:0] A_ZERO = 3'd6;

  localparam logic [3:0] B_RAM   = 4'd0;
  localparam logic [3:0] B_IN    = 4'd1;
  localparam logic [3:0] B_IMASS = 4'd2;
  localparam logic [3:0] B_LKEEP = 4'd3;
  localparam logic [3:0] B_AKEEP = 4'd4;
  localparam logic [3:0] B_DT    = 4'd5;
  localparam logic [3:0] B_ONE   = 4'd6;
  localparam logic [3:0] B_INV6  = 4'd7;
  localparam logic [3:0] B_R     = 4'd8;
  localparam logic [3:0] B_T     = 4'd9;
  localparam logic [3:0] B_F     = 4'd10;

  localparam logic [1:0] ACC_LD  = 2'd0;
  localparam logic [1:0] ACC_ADD = 2'd1;
  localparam logic [1:0] ACC_SUB = 2'd2;

  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_RAM  = 3'd1;
  localparam logic [2:0] D_ROW  = 3'd2;
  localparam logic [2:0] D_M    = 3'd3;
  localparam logic [2:0] D_R    = 3'd4;
  localparam logic [2:0] D_T    = 3'd5;

  localparam logic [5:0] SH_VAR = 6'd0;

  localparam logic [PC_W-1:0] PC_ROW       = 7'd0;
  localparam logic [PC_W-1:0] PC_LOAD_END  = 7'd2;
  localparam logic [PC_W-1:0] PC_STEP      = 7'd3;
  localparam logic [PC_W-1:0] PC_STEP_END  = 7'd55;
  localparam logic [PC_W-1:0] PC_SEED      = 7'd56;
  localparam logic [PC_W-1:0] PC_ITER      = 7'd57;
  localparam logic [PC_W-1:0] PC_ITER_END  = 7'd59;
  localparam logic [PC_W-1:0] PC_FINAL     = 7'd60;
  localparam logic [PC_W-1:0] PC_FINAL_END = 7'd63;
  localparam logic [PC_W-1:0] PC_IDENT     = 7'd64;
  localparam logic [PC_W-1:0] PC_IDENT_END = 7'd67;

  typedef struct packed {
    logic [2:0]        a_sel;
    logic [ADDR_W-1:0] a_addr;
    logic [3:0]        b_sel;
    logic [ADDR_W-1:0] b_addr;
    logic [5:0]        shift;
    logic              rnd;
    logic [1:0]        acc;
    logic [2:0]        dst;
    logic [ADDR_W-1:0] w_addr;
  } op_t;

  typedef struct packed {
    logic              run;
    logic [PC_W-1:0]   pc;
    logic [1:0]        phase;
    logic              init;
    logic [ADDR_W-1:0] init_addr;
    logic              scale;
    logic              capture;
    logic              out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic m_ok;
    logic m_zero;
  } dp_stat_t;

  function automatic op_t mk(logic [2:0] a_sel, logic [ADDR_W-1:0] a_addr,
                             logic [3:0] b_sel, logic [ADDR_W-1:0] b_addr,
                             logic [5:0] shift, logic rnd, logic [1:0] acc,
                             logic [2:0] dst, logic [ADDR_W-1:0] w_addr);
    op_t o;
    o.a_sel = a_sel; o.a_addr = a_addr; o.b_sel = b_sel; o.b_addr = b_addr;
    o.shift = shift; o.rnd = rnd; o.acc = acc; o.dst = dst; o.w_addr = w_addr;
    return o;
  endfunction

  function automatic op_t op_rom(logic [PC_W-1:0] pc);
    op_t o;
    case (pc)
      // tensor row load
      7'd0:  o = mk(A_IN, 6'd0, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_ROW, AT);
      7'd1:  o = mk(A_IN, 6'd1, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_ROW, 6'(AT + 1));
      7'd2:  o = mk(A_IN, 6'd2, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_ROW, 6'(AT + 2));
      // linear x
      7'd3:  o = mk(A_IN, 6'd0, B_IMASS, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, ATMP);
      7'd4:  o = mk(A_RAM, AV, B_LKEEP, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd5:  o = mk(A_RAM, ATMP, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, AV);
      7'd6:  o = mk(A_RAM, AP, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd7:  o = mk(A_RAM, AV, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, AP);
      // linear y
      7'd8:  o = mk(A_IN, 6'd1, B_IMASS, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, ATMP);
      7'd9:  o = mk(A_RAM, 6'(AV + 1), B_LKEEP, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd10: o = mk(A_RAM, ATMP, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, 6'(AV + 1));
      7'd11: o = mk(A_RAM, 6'(AP + 1), B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd12: o = mk(A_RAM, 6'(AV + 1), B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, 6'(AP + 1));
      // linear z
      7'd13: o = mk(A_IN, 6'd2, B_IMASS, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, ATMP);
      7'd14: o = mk(A_RAM, 6'(AV + 2), B_LKEEP, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd15: o = mk(A_RAM, ATMP, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, 6'(AV + 2));
      7'd16: o = mk(A_RAM, 6'(AP + 2), B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd17: o = mk(A_RAM, 6'(AV + 2), B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, 6'(AP + 2));
      // angular x
      7'd18: o = mk(A_RAM, AT, B_IN, 6'd3, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd19: o = mk(A_RAM, 6'(AT + 1), B_IN, 6'd4, 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd20: o = mk(A_RAM, 6'(AT + 2), B_IN, 6'd5, 6'd16, 1'b1, ACC_ADD, D_RAM, ATMP);
      7'd21: o = mk(A_RAM, AW, B_AKEEP, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd22: o = mk(A_RAM, ATMP, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, AW);
      // angular y
      7'd23: o = mk(A_RAM, 6'(AT + 3), B_IN, 6'd3, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd24: o = mk(A_RAM, 6'(AT + 4), B_IN, 6'd4, 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd25: o = mk(A_RAM, 6'(AT + 5), B_IN, 6'd5, 6'd16, 1'b1, ACC_ADD, D_RAM, ATMP);
      7'd26: o = mk(A_RAM, 6'(AW + 1), B_AKEEP, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd27: o = mk(A_RAM, ATMP, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, 6'(AW + 1));
      // angular z
      7'd28: o = mk(A_RAM, 6'(AT + 6), B_IN, 6'd3, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd29: o = mk(A_RAM, 6'(AT + 7), B_IN, 6'd4, 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd30: o = mk(A_RAM, 6'(AT + 8), B_IN, 6'd5, 6'd16, 1'b1, ACC_ADD, D_RAM, ATMP);
      7'd31: o = mk(A_RAM, 6'(AW + 2), B_AKEEP, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd32: o = mk(A_RAM, ATMP, B_DT, 6'd0, 6'd16, 1'b1, ACC_ADD, D_RAM, 6'(AW + 2));
      // half step
      7'd33: o = mk(A_RAM, AW, B_DT, 6'd0, 6'd17, 1'b1, ACC_LD, D_RAM, AH);
      7'd34: o = mk(A_RAM, 6'(AW + 1), B_DT, 6'd0, 6'd17, 1'b1, ACC_LD, D_RAM, 6'(AH + 1));
      7'd35: o = mk(A_RAM, 6'(AW + 2), B_DT, 6'd0, 6'd17, 1'b1, ACC_LD, D_RAM, 6'(AH + 2));
      // quaternion update, w
      7'd36: o = mk(A_RAM, AQ, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd37: o = mk(A_RAM, AH, B_RAM, 6'(AQ + 1), 6'd16, 1'b1, ACC_SUB, D_NONE, 6'd0);
      7'd38: o = mk(A_RAM, 6'(AH + 1), B_RAM, 6'(AQ + 2), 6'd16, 1'b1, ACC_SUB, D_NONE, 6'd0);
      7'd39: o = mk(A_RAM, 6'(AH + 2), B_RAM, 6'(AQ + 3), 6'd16, 1'b1, ACC_SUB, D_RAM, AQN);
      // x
      7'd40: o = mk(A_RAM, 6'(AQ + 1), B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd41: o = mk(A_RAM, AH, B_RAM, AQ, 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd42: o = mk(A_RAM, 6'(AH + 1), B_RAM, 6'(AQ + 3), 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd43: o = mk(A_RAM, 6'(AH + 2), B_RAM, 6'(AQ + 2), 6'd16, 1'b1, ACC_SUB, D_RAM,
                    6'(AQN + 1));
      // y
      7'd44: o = mk(A_RAM, 6'(AQ + 2), B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd45: o = mk(A_RAM, 6'(AH + 1), B_RAM, AQ, 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd46: o = mk(A_RAM, 6'(AH + 2), B_RAM, 6'(AQ + 1), 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd47: o = mk(A_RAM, AH, B_RAM, 6'(AQ + 3), 6'd16, 1'b1, ACC_SUB, D_RAM, 6'(AQN + 2));
      // z
      7'd48: o = mk(A_RAM, 6'(AQ + 3), B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd49: o = mk(A_RAM, 6'(AH + 2), B_RAM, AQ, 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd50: o = mk(A_RAM, AH, B_RAM, 6'(AQ + 2), 6'd16, 1'b1, ACC_ADD, D_NONE, 6'd0);
      7'd51: o = mk(A_RAM, 6'(AH + 1), B_RAM, 6'(AQ + 1), 6'd16, 1'b1, ACC_SUB, D_RAM,
                    6'(AQN + 3));
      // squared norm
      7'd52: o = mk(A_RAM, AQN, B_RAM, AQN, 6'd30, 1'b1, ACC_LD, D_NONE, 6'd0);
      7'd53: o = mk(A_RAM, 6'(AQN + 1), B_RAM, 6'(AQN + 1), 6'd30, 1'b1, ACC_ADD, D_NONE,
                    6'd0);
      7'd54: o = mk(A_RAM, 6'(AQN + 2), B_RAM, 6'(AQN + 2), 6'd30, 1'b1, ACC_ADD, D_NONE,
                    6'd0);
      7'd55: o = mk(A_RAM, 6'(AQN + 3), B_RAM, 6'(AQN + 3), 6'd30, 1'b1, ACC_ADD, D_M, 6'd0);
      // inverse square root
      7'd56: o = mk(A_SEED, 6'd0, B_INV6, 6'd0, 6'd30, 1'b0, ACC_LD, D_R, 6'd0);
      7'd57: o = mk(A_R, 6'd0, B_R, 6'd0, 6'd30, 1'b0, ACC_LD, D_T, 6'd0);
      7'd58: o = mk(A_M, 6'd0, B_T, 6'd0, 6'd30, 1'b0, ACC_LD, D_T, 6'd0);
      7'd59: o = mk(A_R, 6'd0, B_F, 6'd0, 6'd31, 1'b0, ACC_LD, D_R, 6'd0);
      // rescale
      7'd60: o = mk(A_RAM, AQN, B_R, 6'd0, SH_VAR, 1'b1, ACC_LD, D_RAM, AQ);
      7'd61: o = mk(A_RAM, 6'(AQN + 1), B_R, 6'd0, SH_VAR, 1'b1, ACC_LD, D_RAM, 6'(AQ + 1));
      7'd62: o = mk(A_RAM, 6'(AQN + 2), B_R, 6'd0, SH_VAR, 1'b1, ACC_LD, D_RAM, 6'(AQ + 2));
      7'd63: o = mk(A_RAM, 6'(AQN + 3), B_R, 6'd0, SH_VAR, 1'b1, ACC_LD, D_RAM, 6'(AQ + 3));
      // zero norm: identity
      7'd64: o = mk(A_Q30, 6'd0, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, AQ);
      7'd65: o = mk(A_ZERO, 6'd0, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, 6'(AQ + 1));
      7'd66: o = mk(A_ZERO, 6'd0, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, 6'(AQ + 2));
      7'd67: o = mk(A_ZERO, 6'd0, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_RAM, 6'(AQ + 3));
      default: o = mk(A_ZERO, 6'd0, B_ONE, 6'd0, 6'd16, 1'b1, ACC_LD, D_NONE, 6'd0);
    endcase
    return o;
  endfunction

  function automatic logic signed [WORD_W-1:0] reset_word(logic [ADDR_W-1:0] a);
    logic signed [WORD_W-1:0] v;
    v = '0;
    if (a == AQ) v = 32'sh4000_0000;
    if (a == AT || a == 6'(AT + 4) || a == 6'(AT + 8)) v = 32'sd65536;
    return v;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > $signed({{(ACC_W-WORD_W){1'b0}}, 32'h7FFF_FFFF})) r = 32'sh7FFF_FFFF;
    else if (v < $signed({{(ACC_W-WORD_W){1'b1}}, 32'h8000_0000})) r = 32'sh8000_0000;
    else r = v[WORD_W-1:0];
    return r;
  endfunction

endpackage

@@ hdl/rbes_ram.sv @@
module rbes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/rbes_ctrl.sv @@
module rbes_ctrl #(
  parameter int NORM_ITERATIONS = rbes_pkg::NORM_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  output logic                out_valid,
  input  logic                out_ready,
  input  rbes_pkg::dp_stat_t  stat,
  output rbes_pkg::ctl_cmd_t  cmd
);

  localparam int IW = (NORM_ITERATIONS > 1) ? $clog2(NORM_ITERATIONS) : 1;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_SEED  = 4'd6;
  localparam logic [3:0] S_ITER  = 4'd7;
  localparam logic [3:0] S_FINAL = 4'd8;
  localparam logic [3:0] S_IDENT = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]                     state_r, state_nxt;
  logic [rbes_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic [1:0]                     phase_r, phase_nxt;
  logic [rbes_pkg::ADDR_W-1:0]    init_r, init_nxt;
  logic [IW-1:0]                  it_r, it_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           running, op_end;

  assign running = (state_r == S_LOAD) || (state_r == S_STEP) || (state_r == S_SEED) ||
                   (state_r == S_ITER) || (state_r == S_FINAL) || (state_r == S_IDENT);
  assign op_end  = (phase_r == 2'd2);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    init_nxt  = init_r;
    it_nxt    = it_r;
    cmd          = '0;
    cmd.run      = running;
    cmd.pc       = pc_r;
    cmd.phase    = phase_r;
    cmd.init_addr = init_r;
    if (running) phase_nxt = op_end ? 2'd0 : phase_r + 2'd1;
    if (running && op_end) pc_nxt = pc_r + 1'b1;
    unique case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        init_nxt = init_r + 1'b1;
        if (init_r == rbes_pkg::ADDR_W'(rbes_pkg::RAM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        phase_nxt = 2'd0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action) begin
            state_nxt = S_STEP;
            pc_nxt = rbes_pkg::PC_STEP;
          end else begin
            state_nxt = S_LOAD;
            pc_nxt = rbes_pkg::PC_ROW;
          end
        end
      end
      S_LOAD: begin
        if (op_end && pc_r == rbes_pkg::PC_LOAD_END) state_nxt = S_IDLE;
      end
      S_STEP: begin
        if (op_end && pc_r == rbes_pkg::PC_STEP_END) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.m_zero) begin
          state_nxt = S_IDENT;
          pc_nxt = rbes_pkg::PC_IDENT;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (stat.m_ok) begin
          state_nxt = S_SEED;
          pc_nxt = rbes_pkg::PC_SEED;
        end else begin
          cmd.scale = 1'b1;
        end
      end
      S_SEED: begin
        it_nxt = '0;
        if (op_end) state_nxt = S_ITER;
      end
      S_ITER: begin
        if (op_end && pc_r == rbes_pkg::PC_ITER_END) begin
          if (it_r == IW'(NORM_ITERATIONS - 1)) begin
            state_nxt = S_FINAL;
          end else begin
            it_nxt = it_r + 1'b1;
            pc_nxt = rbes_pkg::PC_ITER;
          end
        end
      end
      S_FINAL: begin
        if (op_end && pc_r == rbes_pkg::PC_FINAL_END) state_nxt = S_DONE;
      end
      S_IDENT: begin
        if (op_end && pc_r == rbes_pkg::PC_IDENT_END) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pc_r        <= '0;
      phase_r     <= '0;
      init_r      <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      init_r      <= init_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/rbes_dp.sv @@
module rbes_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rbes_pkg::ctl_cmd_t         cmd,
  output rbes_pkg::dp_stat_t         stat,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [30:0]                cfg_data,
  input  logic                       in_action,
  input  logic [1:0]                 in_row_index,
  input  logic signed [2:0][31:0]    in_row,
  input  logic signed [2:0][31:0]    in_force,
  input  logic signed [2:0][31:0]    in_torque,
  output logic signed [2:0][31:0]    out_pos,
  output logic signed [3:0][31:0]    out_quat,
  output logic signed [2:0][31:0]    out_vel
);

  localparam int W  = rbes_pkg::WORD_W;
  localparam int OW = rbes_pkg::OPND_W;
  localparam int PW = rbes_pkg::PROD_W;
  localparam int CW = rbes_pkg::ACC_W;

  logic [30:0] imass_r;
  logic [16:0] dt_r, lkeep_r, akeep_r;

  logic signed [W-1:0]  in_r [6];
  logic [1:0]           row_r;
  logic signed [PW-1:0] prod_r;
  logic signed [CW-1:0] acc_r, acc_nxt;
  logic [34:0]          m_r;
  logic signed [4:0]    j_r;
  logic [31:0]          r_r;
  logic [33:0]          t_r;
  logic signed [2:0][31:0] pos_m_r, vel_m_r, pos_o_r, vel_o_r;
  logic signed [3:0][31:0] quat_m_r, quat_o_r;

  rbes_pkg::op_t        op;
  logic [W-1:0]         rd_a, rd_b;
  logic                 we;
  logic [rbes_pkg::ADDR_W-1:0] waddr, row_off;
  logic signed [W-1:0]  wdata, res;
  logic signed [OW-1:0] a_op, b_op;
  logic [32:0]          seed;
  logic [31:0]          fpart;
  logic [5:0]           sh;
  logic [PW:0]          half;
  logic signed [PW:0]   pv, sv;
  logic signed [CW-1:0] term;
  logic                 op_wr;

  assign op = rbes_pkg::op_rom(cmd.pc);

  rbes_ram #(.WIDTH(W), .DEPTH(rbes_pkg::RAM_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(op.a_addr), .rdata_a(rd_a), .raddr_b(op.b_addr), .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imass_r <= rbes_pkg::IMASS_RST;
      dt_r    <= rbes_pkg::DT_RST;
      lkeep_r <= rbes_pkg::KEEP_RST;
      akeep_r <= rbes_pkg::KEEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbes_pkg::CFG_IMASS: imass_r <= cfg_data;
        rbes_pkg::CFG_DT:    dt_r    <= cfg_data[16:0];
        rbes_pkg::CFG_LKEEP: lkeep_r <= cfg_data[16:0];
        rbes_pkg::CFG_AKEEP: akeep_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seed  = 33'h1_C000_0000 - {1'b0, m_r[31:0]};
    fpart = (t_r < 34'h0_C000_0000) ? 32'(34'h0_C000_0000 - t_r) : 32'd0;
    case (op.a_sel)
      rbes_pkg::A_RAM:  a_op = OW'($signed(rd_a));
      rbes_pkg::A_IN:   a_op = OW'(in_r[op.a_addr[2:0]]);
      rbes_pkg::A_M:    a_op = $signed({2'b00, m_r[31:0]});
      rbes_pkg::A_R:    a_op = $signed({2'b00, r_r});
      rbes_pkg::A_SEED: a_op = $signed({1'b0, seed});
      rbes_pkg::A_Q30:  a_op = 34'sh0_4000_0000;
      default:          a_op = '0;
    endcase
    case (op.b_sel)
      rbes_pkg::B_RAM:   b_op = OW'($signed(rd_b));
      rbes_pkg::B_IN:    b_op = OW'(in_r[op.b_addr[2:0]]);
      rbes_pkg::B_IMASS: b_op = $signed({3'b000, imass_r});
      rbes_pkg::B_LKEEP: b_op = $signed({17'd0, lkeep_r});
      rbes_pkg::B_AKEEP: b_op = $signed({17'd0, akeep_r});
      rbes_pkg::B_DT:    b_op = $signed({17'd0, dt_r});
      rbes_pkg::B_ONE:   b_op = 34'sd65536;
      rbes_pkg::B_INV6:  b_op = 34'sd178956971;
      rbes_pkg::B_R:     b_op = $signed({2'b00, r_r});
      rbes_pkg::B_T:     b_op = $signed(t_r);
      rbes_pkg::B_F:     b_op = $signed({2'b00, fpart});
      default:           b_op = '0;
    endcase
  end

  // round half up, or truncate, then accumulate
  always_comb begin
    sh   = (op.shift == rbes_pkg::SH_VAR) ? 6'd30 - 6'($signed(j_r)) : op.shift;
    half = op.rnd ? ((PW+1)'(1) << (sh - 6'd1)) : '0;
    pv   = $signed({prod_r[PW-1], prod_r}) + $signed(half);
    sv   = pv >>> sh;
    term = sv[CW-1:0];
    case (op.acc)
      rbes_pkg::ACC_LD:  acc_nxt = term;
      rbes_pkg::ACC_ADD: acc_nxt = acc_r + term;
      rbes_pkg::ACC_SUB: acc_nxt = acc_r - term;
      default:           acc_nxt = acc_r;
    endcase
    res     = rbes_pkg::sat32(acc_nxt);
    op_wr   = cmd.run && (cmd.phase == 2'd2);
    row_off = {3'b000, row_r, 1'b0} + {4'b0000, row_r};
    if (cmd.init) begin
      we    = 1'b1;
      waddr = cmd.init_addr;
      wdata = rbes_pkg::reset_word(cmd.init_addr);
    end else begin
      we    = op_wr && ((op.dst == rbes_pkg::D_RAM) ||
                        (op.dst == rbes_pkg::D_ROW && row_r != 2'd3));
      waddr = (op.dst == rbes_pkg::D_ROW) ? op.w_addr + row_off : op.w_addr;
      wdata = res;
    end
  end

  assign stat.m_ok   = (m_r >= 35'h0_4000_0000) && (m_r < 35'h1_0000_0000);
  assign stat.m_zero = (m_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row_index;
      for (int k = 0; k < 3; k++) begin
        in_r[k]     <= in_action ? in_force[k] : in_row[k];
        in_r[k + 3] <= in_torque[k];
      end
    end
    if (cmd.run && cmd.phase == 2'd1) prod_r <= a_op * b_op;
    if (op_wr) begin
      acc_r <= acc_nxt;
      case (op.dst)
        rbes_pkg::D_M: begin
          m_r <= acc_nxt[34:0];
          j_r <= '0;
        end
        rbes_pkg::D_R: r_r <= acc_nxt[31:0];
        rbes_pkg::D_T: t_r <= acc_nxt[33:0];
        default: ;
      endcase
    end
    if (cmd.scale) begin
      if (m_r < 35'h0_4000_0000) begin
        m_r <= m_r << 2;
        j_r <= j_r + 5'sd1;
      end else begin
        m_r <= m_r >> 2;
        j_r <= j_r - 5'sd1;
      end
    end
    if (we) begin
      for (int k = 0; k < 3; k++) begin
        if (waddr == 6'(rbes_pkg::AP + k)) pos_m_r[k] <= wdata;
        if (waddr == 6'(rbes_pkg::AV + k)) vel_m_r[k] <= wdata;
      end
      for (int k = 0; k < 4; k++) begin
        if (waddr == 6'(rbes_pkg::AQ + k)) quat_m_r[k] <= wdata;
      end
    end
    if (cmd.out_load) begin
      pos_o_r  <= pos_m_r;
      vel_o_r  <= vel_m_r;
      quat_o_r <= quat_m_r;
    end
  end

  assign out_pos  = pos_o_r;
  assign out_vel  = vel_o_r;
  assign out_quat = quat_o_r;

endmodule

@@ hdl/rigid_body_euler_step.sv @@
// Rigid body integrator: one body, semi-implicit Euler step in fixed point.
// Input channel (in_valid/in_ready): in_action 0 loads tensor row in_row_index
// from in_row_x/y/z and gives no result; in_action 1 integrates one step with
// in_force_* and in_torque_*. Result channel (out_valid/out_ready) carries
// position, orientation and linear velocity after each step.
// Config (cfg_we/cfg_index/cfg_data) is to be written only while the block is
// idle; the block itself does not enforce this. One item is in work at a time.
// Every operation of the program runs on one shared 34x34 multiplier as the
// steps operand read, multiply and round/accumulate. Before the inverse square
// root, a step scales the squared norm by powers of four; when the norm is zero
// it sets the orientation to the identity instead. out_valid rises at the same
// edge at which in_ready returns. After reset the state memory is swept to its
// reset values, with in_ready low. The result sits in an output register: the
// next item is accepted while it waits, and a following step holds at its end
// until the receiver has taken the earlier result.
module rigid_body_euler_step #(
  parameter int NORM_ITERATIONS = rbes_pkg::NORM_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_row_x,
  input  logic signed [31:0] in_row_y,
  input  logic signed [31:0] in_row_z,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_force_z,
  input  logic signed [31:0] in_torque_x,
  input  logic signed [31:0] in_torque_y,
  input  logic signed [31:0] in_torque_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z
);

  rbes_pkg::ctl_cmd_t      cmd;
  rbes_pkg::dp_stat_t      stat;
  logic signed [2:0][31:0] pos, vel;
  logic signed [3:0][31:0] quat;

  rbes_ctrl #(.NORM_ITERATIONS(NORM_ITERATIONS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  rbes_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_action(in_action), .in_row_index(in_row_index),
    .in_row({in_row_z, in_row_y, in_row_x}),
    .in_force({in_force_z, in_force_y, in_force_x}),
    .in_torque({in_torque_z, in_torque_y, in_torque_x}),
    .out_pos(pos), .out_quat(quat), .out_vel(vel)
  );

  assign out_pos_x  = pos[0];
  assign out_pos_y  = pos[1];
  assign out_pos_z  = pos[2];
  assign out_quat_w = quat[0];
  assign out_quat_x = quat[1];
  assign out_quat_y = quat[2];
  assign out_quat_z = quat[3];
  assign out_vel_x  = vel[0];
  assign out_vel_y  = vel[1];
  assign out_vel_z  = vel[2];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item in work");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready before state sweep");

  a_no_accept_when_running: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> !in_ready && !cmd.init)
    else $error("sequencer running while idle or sweeping");

endmodule

@@ sim/rigid_body_euler_step_test.sv @@
`timescale 1ns / 1ps

module rigid_body_euler_step_test;

  typedef struct packed {
    logic               action;
    logic [1:0]         row;
    logic signed [31:0] row_x, row_y, row_z;
    logic signed [31:0] force_x, force_y, force_z;
    logic signed [31:0] torque_x, torque_y, torque_z;
  } body_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
  } body_pose_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  body_item_t cur_item = '0;
  body_pose_t dut_pose;

  always #10 clk = ~clk;

  rigid_body_euler_step dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(cur_item.action), .in_row_index(cur_item.row),
    .in_row_x(cur_item.row_x), .in_row_y(cur_item.row_y), .in_row_z(cur_item.row_z),
    .in_force_x(cur_item.force_x), .in_force_y(cur_item.force_y),
    .in_force_z(cur_item.force_z),
    .in_torque_x(cur_item.torque_x), .in_torque_y(cur_item.torque_y),
    .in_torque_z(cur_item.torque_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(dut_pose.pos_x), .out_pos_y(dut_pose.pos_y), .out_pos_z(dut_pose.pos_z),
    .out_quat_w(dut_pose.quat_w), .out_quat_x(dut_pose.quat_x),
    .out_quat_y(dut_pose.quat_y), .out_quat_z(dut_pose.quat_z),
    .out_vel_x(dut_pose.vel_x), .out_vel_y(dut_pose.vel_y), .out_vel_z(dut_pose.vel_z)
  );

  // body model
  longint inv_mass_m, dt_m, lin_keep_m, ang_keep_m;
  longint pos_m[3], vel_m[3], omega_m[3], quat_m[4], tensor_m[9];

  body_pose_t pose_q[$];
  logic typed_pose_valid = 1'b0;
  body_pose_t typed_pose;
  int fails = 0;
  int steps_seen = 0;
  int loads_seen = 0;
  int poses_checked = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int stall_mode = 0;
  int stall_cnt = 0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > longint'(S32_MAX)) return longint'(S32_MAX);
    if (v < longint'(S32_MIN)) return longint'(S32_MIN);
    return v;
  endfunction

  task automatic reset_body();
    inv_mass_m = 65536; dt_m = 1092; lin_keep_m = 65536; ang_keep_m = 65536;
    for (int i = 0; i < 3; i++) begin
      pos_m[i] = 0; vel_m[i] = 0; omega_m[i] = 0;
    end
    quat_m[0] = longint'(Q30_ONE);
    for (int i = 1; i < 4; i++) quat_m[i] = 0;
    for (int i = 0; i < 9; i++) tensor_m[i] = (i % 4 == 0) ? 65536 : 0;
  endtask

  task automatic renormalize_quat();
    longint unsigned n, m, r, t, f;
    int j;
    n = 0;
    j = 0;
    for (int i = 0; i < 4; i++) n += longint'(rnd_shift(quat_m[i] * quat_m[i], 30));
    if (n == 0) begin
      quat_m[0] = longint'(Q30_ONE);
      for (int i = 1; i < 4; i++) quat_m[i] = 0;
    end else begin
      m = n;
      while (m < (64'd1 << 30)) begin
        m = m << 2; j++;
      end
      while (m >= (64'd1 << 32)) begin
        m = m >> 2; j--;
      end
      r = (((64'd7 << 30) - m) * 64'd178956971) >> 30;
      for (int k = 0; k < rbes_pkg::NORM_ITERATIONS_DEF; k++) begin
        t = (m * ((r * r) >> 30)) >> 30;
        f = ((64'd3 << 30) > t) ? (64'd3 << 30) - t : 64'd0;
        r = (r * f) >> 31;
      end
      for (int i = 0; i < 4; i++)
        quat_m[i] = clip32(rnd_shift(quat_m[i] * longint'(r), 30 - j));
    end
  endtask

  task automatic integrate_body(input body_item_t it, output body_pose_t p);
    longint f[3], tq[3], h[3], d[4], a, s;
    f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
    tq[0] = it.torque_x; tq[1] = it.torque_y; tq[2] = it.torque_z;
    for (int i = 0; i < 3; i++) begin
      a = clip32(rnd_shift(inv_mass_m * f[i], 16));
      vel_m[i] = clip32(rnd_shift(vel_m[i] * lin_keep_m, 16) + rnd_shift(a * dt_m, 16));
      pos_m[i] = clip32(pos_m[i] + rnd_shift(vel_m[i] * dt_m, 16));
    end
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int k = 0; k < 3; k++) s += rnd_shift(tensor_m[i * 3 + k] * tq[k], 16);
      s = clip32(s);
      omega_m[i] = clip32(rnd_shift(omega_m[i] * ang_keep_m, 16) + rnd_shift(s * dt_m, 16));
    end
    for (int i = 0; i < 3; i++) h[i] = clip32(rnd_shift(omega_m[i] * dt_m, 17));
    d[0] = -(rnd_shift(h[0] * quat_m[1], 16) + rnd_shift(h[1] * quat_m[2], 16)
             + rnd_shift(h[2] * quat_m[3], 16));
    d[1] = rnd_shift(h[0] * quat_m[0], 16) + rnd_shift(h[1] * quat_m[3], 16)
           - rnd_shift(h[2] * quat_m[2], 16);
    d[2] = rnd_shift(h[1] * quat_m[0], 16) + rnd_shift(h[2] * quat_m[1], 16)
           - rnd_shift(h[0] * quat_m[3], 16);
    d[3] = rnd_shift(h[2] * quat_m[0], 16) + rnd_shift(h[0] * quat_m[2], 16)
           - rnd_shift(h[1] * quat_m[1], 16);
    for (int i = 0; i < 4; i++) quat_m[i] = clip32(quat_m[i] + d[i]);
    renormalize_quat();
    p.pos_x = pos_m[0]; p.pos_y = pos_m[1]; p.pos_z = pos_m[2];
    p.quat_w = quat_m[0]; p.quat_x = quat_m[1]; p.quat_y = quat_m[2]; p.quat_z = quat_m[3];
    p.vel_x = vel_m[0]; p.vel_y = vel_m[1]; p.vel_z = vel_m[2];
  endtask

  // predict on every accepted item
  always @(posedge clk) begin
    body_pose_t p;
    if (rst_n && in_valid && in_ready) begin
      if (cur_item.action == ACT_LOAD) begin
        loads_seen++;
        if (cur_item.row != 2'd3) begin
          tensor_m[cur_item.row * 3]     = cur_item.row_x;
          tensor_m[cur_item.row * 3 + 1] = cur_item.row_y;
          tensor_m[cur_item.row * 3 + 2] = cur_item.row_z;
        end
      end else begin
        steps_seen++;
        integrate_body(cur_item, p);
        pose_q.push_back(typed_pose_valid ? typed_pose : p);
      end
    end
  end

  string field_name[10] = '{"pos_x", "pos_y", "pos_z", "quat_w", "quat_x", "quat_y",
                            "quat_z", "vel_x", "vel_y", "vel_z"};

  always @(posedge clk) begin
    body_pose_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        fails++;
      end else begin
        e = pose_q.pop_front();
        poses_checked++;
        for (int k = 0; k < 10; k++)
          if (e[(9 - k) * 32 +: 32] !== dut_pose[(9 - k) * 32 +: 32]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                     $signed(e[(9 - k) * 32 +: 32]), $signed(dut_pose[(9 - k) * 32 +: 32]));
            fails++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("rigid_body_euler_step_test: FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= $urandom_range(50, 600);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_cnt % 16) < 12;
    endcase
  end

  task automatic send_item(input body_item_t it);
    cur_item = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rbes_pkg::CFG_IMASS: inv_mass_m = val;
      rbes_pkg::CFG_DT:    dt_m = val[16:0];
      rbes_pkg::CFG_LKEEP: lin_keep_m = val[16:0];
      default:             ang_keep_m = val[16:0];
    endcase
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    @(negedge clk);
    while (pose_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return ($urandom_range(0, 1) == 1) ? S32_MAX : S32_MIN;
      2: return int'($urandom_range(0, 2097152)) - 1048576;
      default: return int'($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  function automatic body_item_t rand_item();
    body_item_t it;
    int k;
    k = $urandom_range(0, 19);
    it = '0;
    it.action = ($urandom_range(0, 99) < 15) ? ACT_LOAD : ACT_STEP;
    it.row = $urandom_range(0, 3);
    it.row_x = rand_word(k == 0 ? 0 : (k == 1 ? 1 : 3));
    it.row_y = rand_word(k == 0 ? 0 : (k == 1 ? 1 : 3));
    it.row_z = rand_word(k == 0 ? 0 : (k == 1 ? 1 : 3));
    k = (k < 2) ? k : 2;
    it.force_x = rand_word(k); it.force_y = rand_word(k); it.force_z = rand_word(k);
    it.torque_x = rand_word(k); it.torque_y = rand_word(k); it.torque_z = rand_word(k);
    return it;
  endfunction

  function automatic body_item_t mk_item(logic act, logic [1:0] row, int rx, int ry, int rz,
                                         int fx, int fy, int fz, int tx, int ty, int tz);
    body_item_t it;
    it.action = act; it.row = row; it.row_x = rx; it.row_y = ry; it.row_z = rz;
    it.force_x = fx; it.force_y = fy; it.force_z = fz;
    it.torque_x = tx; it.torque_y = ty; it.torque_z = tz;
    return it;
  endfunction

  body_item_t directed[14];
  logic directed_typed[14];

  initial begin
    body_pose_t rest;
    logic [30:0] imass_v, dt_v, lk_v, ak_v;
    reset_body();
    // renormalizing the identity leaves w one code below one
    rest = '0;
    rest.quat_w = Q30_ONE - 32'sd1;
    directed[0]  = mk_item(ACT_STEP, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    directed[1]  = mk_item(ACT_LOAD, 2'd3, -1, S32_MAX, S32_MIN, 5, 6, 7, 8, 9, 10);
    directed[2]  = mk_item(ACT_STEP, 2'd3, S32_MAX, -1, 12345, 0, 0, 0, 0, 0, 0);
    directed[3]  = mk_item(ACT_LOAD, 2'd0, S32_MAX, S32_MIN, 0, 0, 0, 0, 0, 0, 0);
    directed[4]  = mk_item(ACT_LOAD, 2'd1, -1, 65536, S32_MAX, S32_MAX, 0, 0, 0, 0, 0);
    directed[5]  = mk_item(ACT_LOAD, 2'd2, 0, 0, S32_MIN, 0, 0, 0, S32_MIN, 0, 0);
    directed[6]  = mk_item(ACT_STEP, 2'd1, -1, -1, -1, S32_MAX, S32_MAX, S32_MAX,
                           S32_MIN, S32_MIN, S32_MIN);
    directed[7]  = mk_item(ACT_STEP, 2'd2, 0, 0, 0, S32_MIN, S32_MIN, S32_MIN,
                           S32_MAX, S32_MAX, S32_MAX);
    directed[8]  = mk_item(ACT_STEP, 2'd0, 0, 0, 0, 1, -1, 0, -1, 1, 0);
    directed[9]  = mk_item(ACT_LOAD, 2'd0, 65536, 0, 0, 0, 0, 0, 0, 0, 0);
    directed[10] = mk_item(ACT_LOAD, 2'd1, 0, 65536, 0, 0, 0, 0, 0, 0, 0);
    directed[11] = mk_item(ACT_LOAD, 2'd2, 0, 0, 65536, 0, 0, 0, 0, 0, 0);
    directed[12] = mk_item(ACT_STEP, 2'd0, 0, 0, 0, 65536, -65536, 0, 1000, 2000, -3000);
    directed[13] = mk_item(ACT_STEP, 2'd0, 0, 0, 0, -300000, 70000, 5, 40000, -2, 900000);
    foreach (directed_typed[i]) directed_typed[i] = (i == 0);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset configuration, first step from rest
    foreach (directed[i]) begin
      typed_pose = rest;
      typed_pose_valid = directed_typed[i];
      send_item(directed[i]);
      typed_pose_valid = 1'b0;
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: begin imass_v = 65536; dt_v = 1092; lk_v = 65536; ak_v = 65536; end
        1: begin imass_v = 0; dt_v = 0; lk_v = 0; ak_v = 0; end
        2: begin imass_v = 31'h7FFF_FFFF; dt_v = 65536; lk_v = 65536; ak_v = 65536; end
        3: begin imass_v = 1; dt_v = 131071; lk_v = 131071; ak_v = 70000; end
        4: begin imass_v = 65536; dt_v = 4096; lk_v = 0; ak_v = 65536; end
        default: begin
          imass_v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 262144);
          dt_v = $urandom_range(0, 65536);
          lk_v = $urandom_range(40000, 65536);
          ak_v = $urandom_range(0, 131071);
        end
      endcase
      write_reg(rbes_pkg::CFG_IMASS, imass_v);
      write_reg(rbes_pkg::CFG_DT, dt_v);
      write_reg(rbes_pkg::CFG_LKEEP, lk_v);
      write_reg(rbes_pkg::CFG_AKEEP, ak_v);
      for (int n = 0; n < 230; n++) send_item(rand_item());
    end

    wait_idle();
    $display("covered %0d steps and %0d tensor loads over 9 register settings", steps_seen,
             loads_seen);
    $display("%0d result items checked, %0d mismatches", poses_checked, fails);
    if (fails == 0) begin
      $display("rigid_body_euler_step_test: PASS");
    end else begin
      $display("rigid_body_euler_step_test: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rbes_pkg.sv
hdl/rbes_ram.sv
hdl/rbes_ctrl.sv
hdl/rbes_dp.sv
hdl/rigid_body_euler_step.sv
sim/rigid_body_euler_step_test.sv
